>>> src/waveform_rise_run_check_macros.svh
// Assertion macros for the waveform rise run check block.
// Used by the top level only; no other dependencies.
`ifndef WAVEFORM_RISE_RUN_CHECK_MACROS_SVH
`define WAVEFORM_RISE_RUN_CHECK_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define WRRC_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define WRRC_ASSERT(label, prop, msg) \
  `WRRC_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

>>> src/wrrc_pkg.sv
// Shared types and constants of the waveform rise run check block.
// No dependencies.
`timescale 1ns / 1ps

package wrrc_pkg;

  localparam int APD_SAMPLES_DEF = 512;
  localparam int PMT_SAMPLES_DEF = 512;
  localparam int SURFACE_BINS    = 20;

  localparam int BIN_W = 9;
  localparam int VAL_W = 10;
  localparam int CFG_W = 9;
  localparam int RUN_W = 9;

  // request codes on req_type
  localparam logic [1:0] REQ_BEGIN  = 2'd0;
  localparam logic [1:0] REQ_SAMPLE = 2'd1;
  localparam logic [1:0] REQ_END    = 2'd2;

  // configuration register indexes
  localparam logic CFG_SEARCH_WIDTH   = 1'b0;
  localparam logic CFG_RISE_THRESHOLD = 1'b1;

  localparam logic [CFG_W-1:0] SEARCH_WIDTH_RST   = 9'd10;
  localparam logic [CFG_W-1:0] RISE_THRESHOLD_RST = 9'd4;

  typedef enum logic [1:0] {
    CMD_BEGIN,
    CMD_SAMPLE,
    CMD_END
  } cmd_kind_e;

  // one classified beat from front to back
  typedef struct packed {
    cmd_kind_e         kind;
    logic              flag;    // begin: bin below surface; sample: first of wave
    logic              in_win;  // sample lies inside the open window
    logic [VAL_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic             we;
    logic             idx;
    logic [CFG_W-1:0] data;
  } cfg_wr_t;

endpackage

>>> src/wrrc_fifo.sv
// Small generic queue with registered storage.
// No dependencies.
`timescale 1ns / 1ps

module wrrc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> src/wrrc_front.sv
// Front end: accepts request beats, tracks the bottom bin and classifies
// each sample against its window. Depends on wrrc_pkg.
`timescale 1ns / 1ps

module wrrc_front #(
  parameter int APD_SAMPLES = wrrc_pkg::APD_SAMPLES_DEF,
  parameter int PMT_SAMPLES = wrrc_pkg::PMT_SAMPLES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wrrc_pkg::cfg_wr_t          cfg_i,
  input  logic                       accept_i,
  input  logic [1:0]                 req_type_i,
  input  logic [wrrc_pkg::BIN_W-1:0] bin_first_i,
  input  logic [wrrc_pkg::BIN_W-1:0] bin_second_i,
  input  logic                       use_second_i,
  input  logic                       channel_i,
  input  logic                       first_of_wave_i,
  input  logic [wrrc_pkg::BIN_W-1:0] sample_index_i,
  input  logic [wrrc_pkg::VAL_W-1:0] sample_value_i,
  output logic                       cmd_push_o,
  output wrrc_pkg::cmd_t             cmd_o
);

  import wrrc_pkg::*;

  localparam int MAXS = (APD_SAMPLES > PMT_SAMPLES) ? APD_SAMPLES : PMT_SAMPLES;
  localparam int IW   = (($clog2(MAXS) > BIN_W + 1) ? $clog2(MAXS) : BIN_W + 1) + 2;

  localparam logic signed [IW-1:0] SURF_S   = IW'(SURFACE_BINS);
  localparam logic signed [IW-1:0] APD_LAST = IW'(APD_SAMPLES - 1);
  localparam logic signed [IW-1:0] PMT_LAST = IW'(PMT_SAMPLES - 1);
  localparam logic signed [IW-1:0] APD_LIM  = IW'(APD_SAMPLES - SURFACE_BINS);

  logic [BIN_W-1:0]       bin_q, bin_d, bin_sel;
  logic [CFG_W-1:0]       width_q;
  logic signed [IW-1:0]   bin_s, wid_s, j_s, start_s, end_s, last_s;
  logic                   win_open;

  assign bin_sel = use_second_i ? bin_second_i : bin_first_i;
  assign bin_d   = (accept_i && req_type_i == REQ_BEGIN) ? bin_sel : bin_q;

  always_comb begin
    bin_s   = $signed({{(IW - BIN_W){1'b0}}, bin_q});
    wid_s   = $signed({{(IW - CFG_W){1'b0}}, width_q});
    j_s     = $signed({{(IW - BIN_W){1'b0}}, sample_index_i});
    start_s = bin_s - wid_s;
    if (start_s < SURF_S) begin
      start_s = SURF_S;
    end
    last_s = channel_i ? PMT_LAST : APD_LAST;
    end_s  = bin_s + wid_s;
    if (end_s > last_s) begin
      end_s = last_s;
    end
    win_open = channel_i || (start_s < APD_LIM);
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.value  = sample_value_i;
    cmd_push_o   = accept_i;
    case (req_type_i)
      REQ_BEGIN: begin
        cmd_o.kind = CMD_BEGIN;
        cmd_o.flag = (bin_sel < BIN_W'(SURFACE_BINS));
      end
      REQ_SAMPLE: begin
        cmd_o.kind   = CMD_SAMPLE;
        cmd_o.flag   = first_of_wave_i;
        cmd_o.in_win = win_open && (j_s >= start_s) && (j_s < end_s);
      end
      REQ_END: begin
        cmd_o.kind = CMD_END;
      end
      default: begin
        // unused code: taken and dropped
        cmd_push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q   <= '0;
      width_q <= SEARCH_WIDTH_RST;
    end else begin
      bin_q <= bin_d;
      if (cfg_i.we && cfg_i.idx == CFG_SEARCH_WIDTH) begin
        width_q <= cfg_i.data;
      end
    end
  end

endmodule

>>> src/wrrc_back.sv
// Back end: runs the rise counter over classified beats and produces the
// pass flag on end. Depends on wrrc_pkg.
`timescale 1ns / 1ps

module wrrc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wrrc_pkg::cfg_wr_t cfg_i,
  input  logic              cmd_empty_i,
  input  wrrc_pkg::cmd_t    cmd_i,
  output logic              cmd_pop_o,
  input  logic              out_full_i,
  output logic              out_push_o,
  output logic              out_passed_o
);

  import wrrc_pkg::*;

  logic [CFG_W-1:0] thr_q;
  logic [VAL_W-1:0] prev_q, prev_d;
  logic [RUN_W-1:0] run_q, run_d, run_cmp;
  logic             failed_q, failed_d;
  logic             is_end;

  assign is_end       = (cmd_i.kind == CMD_END);
  assign cmd_pop_o    = !cmd_empty_i && !(is_end && out_full_i);
  assign out_push_o   = cmd_pop_o && is_end;
  assign out_passed_o = !failed_q;

  always_comb begin
    prev_d   = prev_q;
    run_d    = run_q;
    failed_d = failed_q;
    run_cmp  = run_q;
    if (cmd_i.value > prev_q) begin
      run_cmp = (run_q == '1) ? run_q : run_q + 1'b1;
    end else if (cmd_i.value < prev_q) begin
      run_cmp = '0;
    end
    if (cmd_pop_o) begin
      case (cmd_i.kind)
        CMD_BEGIN: begin
          run_d    = '0;
          failed_d = cmd_i.flag;
        end
        CMD_SAMPLE: begin
          prev_d = cmd_i.value;
          if (cmd_i.flag) begin
            run_d = '0;
          end else if (cmd_i.in_win) begin
            run_d = run_cmp;
            if (run_cmp >= thr_q) begin
              failed_d = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= RISE_THRESHOLD_RST;
      prev_q   <= '0;
      run_q    <= '0;
      failed_q <= 1'b0;
    end else begin
      prev_q   <= prev_d;
      run_q    <= run_d;
      failed_q <= failed_d;
      if (cfg_i.we && cfg_i.idx == CFG_RISE_THRESHOLD) begin
        thr_q <= cfg_i.data;
      end
    end
  end

endmodule

>>> src/waveform_rise_run_check.sv
// Top level of the waveform rise run check block: front, command queue,
// back end and result queue. Depends on wrrc_pkg, wrrc_fifo, wrrc_front,
// wrrc_back and the macro header.
//
//  channel   | handshake        | payload
//  ----------+------------------+------------------------------------------
//  request   | push / full      | req_type_i, bins, flags, index, value
//  result    | pop / empty      | passed_o
//  config    | cfg_we_i         | cfg_idx_i, cfg_data_i
//
// One beat a cycle while the queues have room: the front classifies a beat in the
// cycle it is taken, the back retires it once it has passed the command queue.
// A result passes the command queue and then the result queue before pop sees it.
// Reset is asynchronous, active low; no clearing pass is needed.
// A stalled result side blocks the back only on end beats; the two-entry
// queues let push continue until they fill.
`timescale 1ns / 1ps
`include "waveform_rise_run_check_macros.svh"

module waveform_rise_run_check #(
  parameter int APD_SAMPLES = wrrc_pkg::APD_SAMPLES_DEF,
  parameter int PMT_SAMPLES = wrrc_pkg::PMT_SAMPLES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration write port
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [wrrc_pkg::CFG_W-1:0] cfg_data_i,
  // request queue side
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 req_type_i,
  input  logic [wrrc_pkg::BIN_W-1:0] bin_first_i,
  input  logic [wrrc_pkg::BIN_W-1:0] bin_second_i,
  input  logic                       use_second_i,
  input  logic                       channel_i,
  input  logic                       first_of_wave_i,
  input  logic [wrrc_pkg::BIN_W-1:0] sample_index_i,
  input  logic [wrrc_pkg::VAL_W-1:0] sample_value_i,
  // result queue side
  output logic                       empty,
  input  logic                       pop,
  output logic                       passed_o
);

  import wrrc_pkg::*;

  cfg_wr_t cfg;
  cmd_t    front_cmd, back_cmd;
  logic    accept, cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic    out_push, out_full, out_passed;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  wrrc_front #(
    .APD_SAMPLES (APD_SAMPLES),
    .PMT_SAMPLES (PMT_SAMPLES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .accept_i        (accept),
    .req_type_i      (req_type_i),
    .bin_first_i     (bin_first_i),
    .bin_second_i    (bin_second_i),
    .use_second_i    (use_second_i),
    .channel_i       (channel_i),
    .first_of_wave_i (first_of_wave_i),
    .sample_index_i  (sample_index_i),
    .sample_value_i  (sample_value_i),
    .cmd_push_o      (cmd_push),
    .cmd_o           (front_cmd)
  );

  // classified beats between front and back
  wrrc_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (front_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (back_cmd),
    .empty_o (cmd_empty)
  );

  wrrc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_empty_i  (cmd_empty),
    .cmd_i        (back_cmd),
    .cmd_pop_o    (cmd_pop),
    .out_full_i   (out_full),
    .out_push_o   (out_push),
    .out_passed_o (out_passed)
  );

  // finished results wait here for pop
  wrrc_fifo #(
    .WIDTH (1),
    .DEPTH (2)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_passed),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (passed_o),
    .empty_o (empty)
  );

  // a result is never pushed into a full result queue
  `WRRC_ASSERT(a_no_result_overflow, out_push |-> !out_full, "result pushed into full queue")
  // an end beat leaves the command queue only together with its result
  `WRRC_ASSERT(a_end_gives_result, (cmd_pop && back_cmd.kind == CMD_END) |-> out_push,
               "end beat retired without result")
  // the back never idles while work and room are there
  `WRRC_ASSERT(a_back_drains, (!cmd_empty && !out_full) |-> cmd_pop, "back end stalled idly")

endmodule
